FILE: hdl/ctrs_pkg.sv
`timescale 1ns / 1ps

package ctrs_pkg;

    localparam int SLOTS_PER_FRAME_DEF = 30;
    localparam int NUM_TASKS_DEF       = 6;

    // Rate registers exist for every task slot, whether or not the task is checked.
    localparam int TASK_SLOTS = 6;
    localparam int RATE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int TASK_IDX_W = 3;
    localparam int FIELD_W    = 5;

    localparam logic [RATE_W-1:0] RATE_RESET [TASK_SLOTS] = '{
        8'd4, 8'd3, 8'd2, 8'd1, 8'd42, 8'd21
    };

    typedef struct packed {
        logic                  tick;
        logic                  resync;
        logic                  div_init;
        logic                  div_step;
        logic                  release_task;
        logic [TASK_IDX_W-1:0] task_sel;
    } ctrs_cmd_t;

    typedef struct packed {
        logic cur_hit;
        logic out_busy;
    } ctrs_status_t;

endpackage

FILE: hdl/ctrs_datapath.sv
`timescale 1ns / 1ps

module ctrs_datapath import ctrs_pkg::*; #(
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF,
    parameter int NUM_TASKS       = NUM_TASKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0]     cfg_data,
    input  ctrs_cmd_t             cmd,
    output ctrs_status_t          status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TASK_IDX_W-1:0] m_task_index,
    output logic [FIELD_W-1:0]    m_slot_number,
    output logic [FIELD_W-1:0]    m_release_number,
    output logic                  m_last_release
);

    localparam int SW = $clog2(SLOTS_PER_FRAME + 1);

    logic [RATE_W-1:0]     rate_reg [TASK_SLOTS];
    logic [SW-1:0]         slot_reg;
    logic [SW-1:0]         sh_reg;
    logic [SW-1:0]         rem_reg  [NUM_TASKS];
    logic [SW-1:0]         cnt_reg  [NUM_TASKS];
    logic [SW-1:0]         eff_rate [NUM_TASKS];
    logic [SW-1:0]         period   [NUM_TASKS];
    logic [SW-1:0]         period_tab [SLOTS_PER_FRAME + 1];
    logic [NUM_TASKS-1:0]  hit;

    logic                  m_valid_reg;
    logic [TASK_IDX_W-1:0] m_task_reg;
    logic [FIELD_W-1:0]    m_slot_reg;
    logic [FIELD_W-1:0]    m_rel_reg;
    logic                  m_last_reg;

    logic                  sel_hit;
    logic                  later_hit;
    logic [SW-1:0]         sel_cnt_next;

    // Frame length divided by each possible effective rate, resolved at elaboration.
    for (genvar g = 0; g <= SLOTS_PER_FRAME; g++) begin : g_period
        localparam int PV = (g == 0) ? 0 : SLOTS_PER_FRAME / g;
        assign period_tab[g] = SW'(PV);
    end

    always_comb begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (rate_reg[t] > RATE_W'(SLOTS_PER_FRAME)) begin
                eff_rate[t] = SW'(SLOTS_PER_FRAME);
            end else begin
                eff_rate[t] = rate_reg[t][SW-1:0];
            end
            period[t] = period_tab[eff_rate[t]];
            hit[t]    = (eff_rate[t] != '0) && (rem_reg[t] == '0) && (cnt_reg[t] < eff_rate[t]);
        end
    end

    always_comb begin
        sel_hit      = 1'b0;
        later_hit    = 1'b0;
        sel_cnt_next = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (TASK_IDX_W'(t) == cmd.task_sel) begin
                sel_hit      = hit[t];
                sel_cnt_next = cnt_reg[t] + SW'(1);
            end
            if (TASK_IDX_W'(t) > cmd.task_sel && hit[t]) begin
                later_hit = 1'b1;
            end
        end
    end

    assign status.cur_hit  = sel_hit;
    assign status.out_busy = m_valid_reg && !m_ready;

    // Rate registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                rate_reg[i] <= RATE_RESET[i];
            end
        end else if (cfg_valid) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    rate_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Slot counter and per-task release counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            for (int t = 0; t < NUM_TASKS; t++) begin
                cnt_reg[t] <= '0;
            end
        end else if (cmd.tick) begin
            if (cmd.resync || slot_reg >= SW'(SLOTS_PER_FRAME)) begin
                slot_reg <= SW'(1);
                for (int t = 0; t < NUM_TASKS; t++) begin
                    cnt_reg[t] <= '0;
                end
            end else begin
                slot_reg <= slot_reg + SW'(1);
            end
        end else if (cmd.release_task) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (TASK_IDX_W'(t) == cmd.task_sel) begin
                    cnt_reg[t] <= sel_cnt_next;
                end
            end
        end
    end

    // One restoring remainder lane per task, one slot bit per cycle
    always_ff @(posedge aclk) begin
        logic [SW:0] trial;
        if (cmd.div_init) begin
            sh_reg <= slot_reg;
            for (int t = 0; t < NUM_TASKS; t++) begin
                rem_reg[t] <= '0;
            end
        end else if (cmd.div_step) begin
            sh_reg <= sh_reg << 1;
            for (int t = 0; t < NUM_TASKS; t++) begin
                trial = {rem_reg[t], sh_reg[SW-1]};
                if (trial >= {1'b0, period[t]}) begin
                    trial = trial - {1'b0, period[t]};
                end
                rem_reg[t] <= trial[SW-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.release_task) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.release_task) begin
            m_task_reg <= cmd.task_sel + TASK_IDX_W'(1);
            m_slot_reg <= FIELD_W'(slot_reg);
            m_rel_reg  <= FIELD_W'(sel_cnt_next);
            m_last_reg <= !later_hit;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_task_index     = m_task_reg;
    assign m_slot_number    = m_slot_reg;
    assign m_release_number = m_rel_reg;
    assign m_last_release   = m_last_reg;

endmodule

FILE: hdl/ctrs_controller.sv
`timescale 1ns / 1ps

module ctrs_controller import ctrs_pkg::*; #(
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF,
    parameter int NUM_TASKS       = NUM_TASKS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_resync,
    input  ctrs_status_t status,
    output ctrs_cmd_t    cmd
);

    localparam int SW = $clog2(SLOTS_PER_FRAME + 1);
    localparam int CW = (SW > 1) ? $clog2(SW) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_SCAN
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         step_reg;
    logic [TASK_IDX_W-1:0] task_reg;
    logic                  ready_reg;
    logic                  accept;
    logic                  can_release;

    assign accept      = s_valid && ready_reg;
    assign can_release = (state_reg == ST_SCAN) && status.cur_hit && !status.out_busy;

    always_comb begin
        cmd              = '0;
        cmd.tick         = accept;
        cmd.resync       = s_resync;
        cmd.div_init     = (state_reg == ST_INIT);
        cmd.div_step     = (state_reg == ST_DIV);
        cmd.release_task = can_release;
        cmd.task_sel     = task_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            task_reg  <= '0;
            ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    step_reg  <= CW'(SW - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        task_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        step_reg <= step_reg - CW'(1);
                    end
                end
                ST_SCAN: begin
                    // hold on a hit while the output register is still occupied
                    if (!status.cur_hit || can_release) begin
                        if (task_reg == TASK_IDX_W'(NUM_TASKS - 1)) begin
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            task_reg <= task_reg + TASK_IDX_W'(1);
                        end
                    end
                end
                default: begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = ready_reg;

endmodule

FILE: hdl/cyclic_task_release_sequencer.sv
`timescale 1ns / 1ps
// After a tick is accepted, the controller passes through ST_INIT and then ST_DIV, where the
// bit-serial remainder lanes work through the slot bits, and then ST_SCAN checks the tasks in
// order, task one first, one task per cycle while m_ready does not hold off a release; each
// release beat is registered. s_ready stays low from the accepted tick until the scan of the
// last task ends, so a new tick is not taken before the last one is through.
// Reset (aresetn, synchronous, active low): rates to defaults, slot counter and counts to zero.

module cyclic_task_release_sequencer import ctrs_pkg::*; #(
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF,
    parameter int NUM_TASKS       = NUM_TASKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0]     cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_resync,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TASK_IDX_W-1:0] m_task_index,
    output logic [FIELD_W-1:0]    m_slot_number,
    output logic [FIELD_W-1:0]    m_release_number,
    output logic                  m_last_release
);

    ctrs_cmd_t    cmd;
    ctrs_status_t status;

    assign cfg_ready = 1'b1;

    ctrs_controller #(
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME),
        .NUM_TASKS       (NUM_TASKS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_resync (s_resync),
        .status   (status),
        .cmd      (cmd)
    );

    ctrs_datapath #(
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME),
        .NUM_TASKS       (NUM_TASKS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_task_index     (m_task_index),
        .m_slot_number    (m_slot_number),
        .m_release_number (m_release_number),
        .m_last_release   (m_last_release)
    );

endmodule
